// ===== hdl/dele_pkg.sv =====
package dele_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CODE_BITS = 8;
  localparam int CFG_INDEX_BITS = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIGIT_BITS = 4;

  localparam logic [CODE_BITS-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CODE_BITS-1:0] CHAR_NINE = 8'h39;
  localparam logic [CODE_BITS-1:0] ENTER_RESET = 8'd13;
  localparam logic [CODE_BITS-1:0] ERASE_RESET = 8'd8;
  localparam logic [DIGIT_BITS-1:0] RADIX = 4'd10;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENTER = 8'd0,
    REG_ERASE = 8'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_DIGIT  = 2'd1,
    OP_ERASE  = 2'd2,
    OP_ENTER  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [CODE_BITS-1:0] ch;
  } cmd_t;

endpackage

// ===== hdl/dele_if.sv =====
interface dele_char_if import dele_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] in_char;

  modport source(output valid, output in_char, input ready);
  modport sink(input valid, input in_char, output ready);
endinterface

interface dele_res_if import dele_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  echo_valid;
  logic [CODE_BITS-1:0]  echo_char;
  logic                  done_res;
  logic [VALUE_BITS-1:0] value;
  logic                  wrapped;

  modport source(output valid, output echo_valid, output echo_char, output done_res,
                 output value, output wrapped, input ready);
  modport sink(input valid, input echo_valid, input echo_char, input done_res,
               input value, input wrapped, output ready);
endinterface

// ===== hdl/dele_front.sv =====
module dele_front import dele_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CODE_BITS-1:0]      cfg_data,
  dele_char_if.sink                 chars,
  output logic                      push,
  output cmd_t                      push_cmd,
  input  logic                      full
);

  logic [CODE_BITS-1:0] enter_code;
  logic [CODE_BITS-1:0] erase_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_code <= ENTER_RESET;
      erase_code <= ERASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTER: enter_code <= cfg_data;
        REG_ERASE: erase_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign chars.ready = !full;
  assign push = chars.valid && !full;

  // The enter code wins over digits, and digits win over the erase code.
  always_comb begin
    push_cmd.ch = chars.in_char;
    if (chars.in_char == enter_code) begin
      push_cmd.op = OP_ENTER;
    end else if (chars.in_char >= CHAR_ZERO && chars.in_char <= CHAR_NINE) begin
      push_cmd.op = OP_DIGIT;
    end else if (chars.in_char == erase_code) begin
      push_cmd.op = OP_ERASE;
    end else begin
      push_cmd.op = OP_IGNORE;
    end
  end

endmodule

// ===== hdl/dele_queue.sv =====
module dele_queue import dele_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                 entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wptr;
  logic [PTR_BITS-1:0]  rptr;
  logic [FILL_BITS-1:0] fill;

  assign full = (fill == FILL_BITS'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dele_back.sv =====
module dele_back import dele_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  dele_res_if.source  results
);

  localparam int PROD_BITS = VALUE_BITS + DIGIT_BITS;
  localparam int RECIP_SHIFT = VALUE_BITS + 3;
  localparam logic [PROD_BITS-1:0] RECIP_POW = {1'b1, {RECIP_SHIFT{1'b0}}};
  localparam logic [PROD_BITS-1:0] RECIP_WIDE =
    RECIP_POW / {{VALUE_BITS{1'b0}}, RADIX} + 1'b1;
  localparam logic [VALUE_BITS-1:0] RECIP = RECIP_WIDE[VALUE_BITS-1:0];

  logic [VALUE_BITS-1:0]   acc;
  logic [COUNT_BITS-1:0]   cnt;
  logic                    wrap;
  logic                    out_valid;

  logic                    can_out;
  logic [CODE_BITS-1:0]    digit_full;
  logic [PROD_BITS-1:0]    acc_ext;
  logic [PROD_BITS-1:0]    prod;
  logic                    wrap_now;
  logic [2*VALUE_BITS-1:0] recip_prod;
  logic [VALUE_BITS-1:0]   acc_tenth;

  logic                    res_echo_valid;
  logic [CODE_BITS-1:0]    res_echo_char;
  logic                    res_done;
  logic [VALUE_BITS-1:0]   res_value;
  logic                    res_wrapped;

  assign can_out = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign pop = head_valid && can_out;

  assign digit_full = head_cmd.ch - CHAR_ZERO;
  assign acc_ext = {{DIGIT_BITS{1'b0}}, acc};
  assign prod = (acc_ext << 3) + (acc_ext << 1)
              + {{VALUE_BITS{1'b0}}, digit_full[DIGIT_BITS-1:0]};
  assign wrap_now = (prod[PROD_BITS-1:VALUE_BITS] != '0);

  // Division by ten as a multiplication by the rounded-up reciprocal.
  assign recip_prod = {{VALUE_BITS{1'b0}}, acc} * {{VALUE_BITS{1'b0}}, RECIP};
  assign acc_tenth = {3'b000, recip_prod[2*VALUE_BITS-1:RECIP_SHIFT]};

  always_comb begin
    res_echo_valid = 1'b0;
    res_echo_char = '0;
    res_done = 1'b0;
    res_value = '0;
    res_wrapped = wrap;
    case (head_cmd.op)
      OP_ENTER: begin
        res_done = 1'b1;
        res_value = acc;
      end
      OP_DIGIT: begin
        res_echo_valid = 1'b1;
        res_echo_char = head_cmd.ch;
        res_wrapped = wrap | wrap_now;
      end
      OP_ERASE: begin
        if (cnt != '0) begin
          res_echo_valid = 1'b1;
          res_echo_char = head_cmd.ch;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      wrap <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        case (head_cmd.op)
          OP_ENTER: begin
            acc <= '0;
            cnt <= '0;
            wrap <= 1'b0;
          end
          OP_DIGIT: begin
            acc <= prod[VALUE_BITS-1:0];
            wrap <= wrap | wrap_now;
            if (cnt != '1) begin
              cnt <= cnt + 1'b1;
            end
          end
          OP_ERASE: begin
            if (cnt != '0) begin
              acc <= acc_tenth;
              cnt <= cnt - 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.echo_valid <= res_echo_valid;
      results.echo_char <= res_echo_char;
      results.done_res <= res_done;
      results.value <= res_value;
      results.wrapped <= res_wrapped;
    end
  end

  a_enter_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head_cmd.op == OP_ENTER) |=> (acc == '0 && cnt == '0 && !wrap))
    else $error("enter request did not clear the entry state");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=>
      (out_valid && $stable(results.value) && $stable(results.echo_char)))
    else $error("waiting result changed or was dropped");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    (wrap && !(pop && head_cmd.op == OP_ENTER)) |=> wrap)
    else $error("wrap flag cleared before the enter request");

endmodule

// ===== hdl/decimal_entry_line_editor.sv =====
// Channel    Role     Handshake      Payload
// chars      sink     valid/ready    in_char
// results    source   valid/ready    echo_valid, echo_char, done_res, value, wrapped
// cfg        write    cfg_we         cfg_index (0 enter_code, 1 erase_code), cfg_data
//
// Each request, an erase included, is executed on pop into the registered result, so a
// request can be accepted every cycle while the output is free or results.ready is high.
// A two-entry queue separates classification from execution.
// Synchronous active-high reset sets the codes to 13 and 8 and clears the control state.
// A result waits in the output register while results.ready is low; once the queue holds
// two requests, chars.ready goes low.
module decimal_entry_line_editor import dele_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CODE_BITS-1:0]      cfg_data,
  dele_char_if.sink                 chars,
  dele_res_if.source                results
);

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  dele_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (chars),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  dele_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dele_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .results    (results)
  );

endmodule
